>>> rtl/core/ncthr_pkg.sv
// Package for the normalised correlation threshold block.
// Holds the shared widths, register indexes, controller states and the
// command and status bundles between the controller and the datapath.
`default_nettype none

package ncthr_pkg;

   // Fixed widths of the arithmetic
   localparam int ACC_BITS      = 56;                  // accumulator width, wraps
   localparam int SCORE_BITS    = 16;                  // Q1.14 score
   localparam int Q_BITS        = 15;                  // magnitude 0..16384
   localparam int KSQ_BITS      = 30;                  // (2q-1)^2 < 2^30
   localparam int RHS_SHIFT     = 30;                  // m^2 * 2^30
   localparam int PROD_BITS     = 2 * ACC_BITS + RHS_SHIFT;
   localparam int STEP_BITS     = $clog2(ACC_BITS);
   localparam int BIT_BITS      = 4;
   localparam int TOP_BIT       = 14;
   localparam int SCORE_ONE     = 16384;

   // Defaults for the top-level parameters
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 24;

   // Register port
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_KEEP_SIGN = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_THRESHOLD = 1'b1;
   localparam logic signed [SCORE_BITS-1:0] THRESH_RESET = 16'sd1638;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_FIN,
      ST_PROD,
      ST_SQR_LD,
      ST_SQR,
      ST_RHS,
      ST_BIT,
      ST_LHS_LD,
      ST_LHS,
      ST_CMP,
      ST_DONE
   } state_type;

   // Operand choice for the shared serial multiplier
   typedef enum logic [1:0] {
      MS_NORM,   // energy_a * energy_b
      MS_SQR,    // |dot| * |dot|
      MS_LHS     // (2t-1)^2 * energy product
   } mul_sel_type;

   typedef struct packed {
      logic                load_sample;
      logic                mul_prod;
      logic                acc_step;
      logic                q_clear;
      logic                mul_load;
      mul_sel_type         mul_sel;
      logic                mul_step;
      logic                save_prod;
      logic                save_rhs;
      logic                ksq_load;
      logic                cmp_update;
      logic                load_rsp;
      logic [BIT_BITS-1:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic zero_norm;
      logic t_over;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/ncthr_datapath.sv
// Datapath: sample products, accumulators, shared shift-add multiplier,
// score search registers and the result register.
// Depends on ncthr_pkg; driven by ncthr_ctrl through cmd_type.
`default_nettype none

module ncthr_datapath #(
   parameter int SAMPLE_BITS = ncthr_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = ncthr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic signed [SAMPLE_BITS-1:0]           sample_a,
   input  wire logic signed [SAMPLE_BITS-1:0]           sample_b,
   input  wire logic                                    last,
   input  wire logic                                    csr_we,
   input  wire logic [ncthr_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  wire logic [ncthr_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  wire ncthr_pkg::cmd_type                      cmd,
   output ncthr_pkg::status_type                        status,
   output logic signed [ncthr_pkg::SCORE_BITS-1:0]      score,
   output logic                                         above_threshold,
   output logic                                         zero_norm,
   output logic                                         overflow
);

   localparam int ACC   = ncthr_pkg::ACC_BITS;
   localparam int PB    = ncthr_pkg::PROD_BITS;
   localparam int QB    = ncthr_pkg::Q_BITS;
   localparam int SB    = ncthr_pkg::SCORE_BITS;
   localparam int KB    = ncthr_pkg::KSQ_BITS;
   localparam int MULB  = 2 * SAMPLE_BITS;

   // Configuration registers
   logic                 keep_sign_ff;
   logic signed [SB-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_sign_ff <= 1'b0;
         thr_ff       <= ncthr_pkg::THRESH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ncthr_pkg::CSR_KEEP_SIGN: keep_sign_ff <= csr_wdata[0];
            ncthr_pkg::CSR_THRESHOLD: thr_ff       <= csr_wdata[SB-1:0];
            default: ;
         endcase
      end
   end

   // Sample capture and products
   logic signed [SAMPLE_BITS-1:0] a_ff, b_ff;
   logic                          last_ff;
   logic signed [MULB-1:0]        pab_ff, paa_ff, pbb_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         a_ff    <= sample_a;
         b_ff    <= sample_b;
         last_ff <= last;
      end
      if (cmd.mul_prod) begin
         pab_ff <= a_ff * b_ff;
         paa_ff <= a_ff * a_ff;
         pbb_ff <= b_ff * b_ff;
      end
   end

   // Accumulators, cleared once the result is registered
   logic [ACC-1:0]        dot_ff, ea_ff, eb_ff;
   logic [COUNT_BITS:0]   cnt_ff;
   logic                  ovf_ff;
   logic [ACC-1:0]        pab_ext, paa_ext, pbb_ext;

   assign pab_ext = {{(ACC-MULB){pab_ff[MULB-1]}}, pab_ff};
   assign paa_ext = {{(ACC-MULB){paa_ff[MULB-1]}}, paa_ff};
   assign pbb_ext = {{(ACC-MULB){pbb_ff[MULB-1]}}, pbb_ff};

   always_ff @(posedge clock) begin
      if (reset || cmd.load_rsp) begin
         dot_ff <= '0;
         ea_ff  <= '0;
         eb_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.acc_step) begin
         if (cnt_ff[COUNT_BITS]) begin
            ovf_ff <= 1'b1;
         end else begin
            dot_ff <= dot_ff + pab_ext;
            ea_ff  <= ea_ff + paa_ext;
            eb_ff  <= eb_ff + pbb_ext;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Magnitude of the dot product
   logic           dot_neg;
   logic [ACC-1:0] dot_mag;
   assign dot_neg = dot_ff[ACC-1];
   assign dot_mag = dot_neg ? (~dot_ff + 1'b1) : dot_ff;

   // Score search: trial value and its squared odd form
   logic [QB-1:0] q_ff, t_val;
   logic [QB:0]   k_val;
   logic [KB-1:0] ksq_ff;
   logic [2*QB+1:0] k_sq;

   assign t_val = q_ff | (QB'(1) << cmd.bit_idx);
   assign k_val = {t_val, 1'b0} - 1'b1;
   assign k_sq  = k_val * k_val;

   // Shared shift-add multiplier, one multiplier bit per cycle
   logic [PB-1:0]       macc_ff, mcand_ff;
   logic [ACC-1:0]      mplier_ff;
   logic [2*ACC-1:0]    prod_ff;
   logic [PB-1:0]       rhs_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         macc_ff <= '0;
         case (cmd.mul_sel)
            ncthr_pkg::MS_NORM: begin
               mcand_ff  <= PB'(ea_ff);
               mplier_ff <= eb_ff;
            end
            ncthr_pkg::MS_SQR: begin
               mcand_ff  <= PB'(dot_mag);
               mplier_ff <= dot_mag;
            end
            ncthr_pkg::MS_LHS: begin
               mcand_ff  <= PB'(prod_ff);
               mplier_ff <= ACC'(ksq_ff);
            end
            default: begin
               mcand_ff  <= '0;
               mplier_ff <= '0;
            end
         endcase
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) macc_ff <= macc_ff + mcand_ff;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
      if (cmd.save_prod) prod_ff <= macc_ff[2*ACC-1:0];
      if (cmd.save_rhs)  rhs_ff  <= {macc_ff[PB-ncthr_pkg::RHS_SHIFT-1:0],
                                     {ncthr_pkg::RHS_SHIFT{1'b0}}};
      if (cmd.ksq_load)  ksq_ff  <= k_sq[KB-1:0];
   end

   // Keep the trial bit when (2t-1)^2 * ea * eb <= m^2 * 2^30
   always_ff @(posedge clock) begin
      if (cmd.q_clear) begin
         q_ff <= '0;
      end else if (cmd.cmp_update && (macc_ff <= rhs_ff)) begin
         q_ff <= t_val;
      end
   end

   assign status.last      = last_ff;
   assign status.zero_norm = (ea_ff == '0) || (eb_ff == '0);
   assign status.t_over    = t_val > QB'(ncthr_pkg::SCORE_ONE);

   // Result register
   logic signed [SB-1:0] score_val;
   logic signed [SB-1:0] score_ff;
   logic                 above_ff, zero_ff, ovf_out_ff;

   assign score_val = (keep_sign_ff && dot_neg) ? -$signed(SB'(q_ff)) : $signed(SB'(q_ff));

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         score_ff   <= score_val;
         above_ff   <= score_val > thr_ff;
         zero_ff    <= status.zero_norm;
         ovf_out_ff <= ovf_ff;
      end
   end

   assign score           = score_ff;
   assign above_threshold = above_ff;
   assign zero_norm       = zero_ff;
   assign overflow        = ovf_out_ff;

endmodule

`default_nettype wire

>>> rtl/core/ncthr_ctrl.sv
// Controller: sequences accumulation, the serial multiplications and the
// bitwise score search, and owns the input and result handshakes.
// Depends on ncthr_pkg; drives ncthr_datapath through cmd_type.
`default_nettype none

module ncthr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire ncthr_pkg::status_type  status,
   output ncthr_pkg::cmd_type          cmd
);

   localparam int ACC = ncthr_pkg::ACC_BITS;

   ncthr_pkg::state_type                 state_ff, state_in;
   logic [ncthr_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [ncthr_pkg::BIT_BITS-1:0]       bit_ff, bit_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 step_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncthr_pkg::ST_IDLE;
         step_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign step_end = (step_ff == ncthr_pkg::STEP_BITS'(ACC - 1));

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      cmd.mul_sel = ncthr_pkg::MS_NORM;
      cmd.bit_idx = bit_ff;
      req_tready  = 1'b0;
      case (state_ff)
         ncthr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_sample = 1'b1;
               state_in = ncthr_pkg::ST_MUL;
            end
         end
         ncthr_pkg::ST_MUL: begin
            cmd.mul_prod = 1'b1;
            state_in = ncthr_pkg::ST_ACC;
         end
         ncthr_pkg::ST_ACC: begin
            cmd.acc_step = 1'b1;
            state_in = status.last ? ncthr_pkg::ST_FIN : ncthr_pkg::ST_IDLE;
         end
         ncthr_pkg::ST_FIN: begin
            cmd.q_clear = 1'b1;
            if (status.zero_norm) begin
               state_in = ncthr_pkg::ST_DONE;
            end else begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = ncthr_pkg::MS_NORM;
               step_in  = '0;
               state_in = ncthr_pkg::ST_PROD;
            end
         end
         ncthr_pkg::ST_PROD: begin
            cmd.mul_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_end) state_in = ncthr_pkg::ST_SQR_LD;
         end
         ncthr_pkg::ST_SQR_LD: begin
            cmd.save_prod = 1'b1;
            cmd.mul_load  = 1'b1;
            cmd.mul_sel   = ncthr_pkg::MS_SQR;
            step_in  = '0;
            state_in = ncthr_pkg::ST_SQR;
         end
         ncthr_pkg::ST_SQR: begin
            cmd.mul_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_end) state_in = ncthr_pkg::ST_RHS;
         end
         ncthr_pkg::ST_RHS: begin
            cmd.save_rhs = 1'b1;
            bit_in   = ncthr_pkg::BIT_BITS'(ncthr_pkg::TOP_BIT);
            state_in = ncthr_pkg::ST_BIT;
         end
         ncthr_pkg::ST_BIT: begin
            if (status.t_over) begin
               if (bit_ff == '0) state_in = ncthr_pkg::ST_DONE;
               else bit_in = bit_ff - 1'b1;
            end else begin
               cmd.ksq_load = 1'b1;
               state_in = ncthr_pkg::ST_LHS_LD;
            end
         end
         ncthr_pkg::ST_LHS_LD: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sel  = ncthr_pkg::MS_LHS;
            step_in  = '0;
            state_in = ncthr_pkg::ST_LHS;
         end
         ncthr_pkg::ST_LHS: begin
            cmd.mul_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_end) state_in = ncthr_pkg::ST_CMP;
         end
         ncthr_pkg::ST_CMP: begin
            cmd.cmp_update = 1'b1;
            if (bit_ff == '0) begin
               state_in = ncthr_pkg::ST_DONE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ncthr_pkg::ST_BIT;
            end
         end
         ncthr_pkg::ST_DONE: begin
            // wait for the result slot to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in = ncthr_pkg::ST_IDLE;
            end
         end
         default: state_in = ncthr_pkg::ST_IDLE;
      endcase
   end

   // Result valid: set on load, cleared by a transfer
   always_comb begin
      if (cmd.load_rsp)                      rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_tready)   rsp_valid_in = 1'b0;
      else                                   rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncthr_pkg::ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_prod_to_sqr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncthr_pkg::ST_PROD && step_end) |=> state_ff == ncthr_pkg::ST_SQR_LD)
      else $error("energy product not completed after full pass");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncthr_pkg::ST_BIT) |-> bit_ff <= ncthr_pkg::BIT_BITS'(ncthr_pkg::TOP_BIT))
      else $error("score bit index out of range");

endmodule

`default_nettype wire

>>> rtl/core/normalized_correlation_threshold_top.sv
// Channel   Dir  Handshake                 Payload
// req_      in   req_tvalid / req_tready   tdata: sample_a, sample_b; tlast: last
// rsp_      out  rsp_tvalid / rsp_tready   tdata: score; tuser: above, zero_norm, overflow
// csr_      in   csr_we                    csr_addr, csr_wdata
//
// A non-last pair passes through capture, multiply and accumulate.
// A last pair adds the score search on one shift-add multiplier, one bit a
// cycle: two full multiplications, then one more for each of up to 15 score bits.
// Synchronous active-high reset; a result waits in its register while the next
// volume streams in, and only a finished score stalls for the result slot.
// Depends on ncthr_pkg, ncthr_ctrl and ncthr_datapath.
`default_nettype none

module normalized_correlation_threshold_top #(
   parameter int SAMPLE_BITS = ncthr_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = ncthr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // sample_a [SAMPLE_BITS-1:0], sample_b above it, zero padding to bytes
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // score [15:0]
   output logic [ncthr_pkg::SCORE_BITS-1:0]          rsp_tdata,
   // above_threshold [0], zero_norm [1], overflow [2]
   output logic [2:0]                                rsp_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [ncthr_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [ncthr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   ncthr_pkg::cmd_type    cmd;
   ncthr_pkg::status_type status;
   logic signed [ncthr_pkg::SCORE_BITS-1:0] score;
   logic above, zero, ovf;

   ncthr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ncthr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .sample_a        (req_tdata[SAMPLE_BITS-1:0]),
      .sample_b        (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .last            (req_tlast),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .score           (score),
      .above_threshold (above),
      .zero_norm       (zero),
      .overflow        (ovf)
   );

   assign rsp_tdata = score;
   assign rsp_tuser = {ovf, zero, above};

endmodule

`default_nettype wire
